### src/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg - shared types and codes for the midpoint line rasterizer
// Item mode codes, slope case codes and the fixed color width.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COLOR_BITS = 24;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef enum logic [2:0] {
        OCT_HORZ       = 3'd0,
        OCT_DIAG_UP    = 3'd1,
        OCT_DIAG_DN    = 3'd2,
        OCT_VERT       = 3'd3,
        OCT_SHALLOW_UP = 3'd4,
        OCT_STEEP_UP   = 3'd5,
        OCT_SHALLOW_DN = 3'd6,
        OCT_STEEP_DN   = 3'd7
    } t_octant;

endpackage

### src/mlr_setup.sv
// ----------------------------------------------------------------------------
// mlr_setup - line setup
// Orders the endpoints, classifies the slope and seeds the decision term.
// ----------------------------------------------------------------------------
module mlr_setup
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]        i_x0,
    input  logic [COORD_BITS-1:0]        i_y0,
    input  logic [COORD_BITS-1:0]        i_x1,
    input  logic [COORD_BITS-1:0]        i_y1,
    output logic [COORD_BITS-1:0]        o_cur_x,
    output logic [COORD_BITS-1:0]        o_cur_y,
    output logic [COORD_BITS-1:0]        o_stop_x,
    output logic [COORD_BITS-1:0]        o_stop_y,
    output logic [COORD_BITS:0]          o_delta_x,
    output logic signed [COORD_BITS:0]   o_delta_y,
    output logic signed [COORD_BITS+2:0] o_decision,
    output t_octant                      o_octant
);

    localparam int DW = COORD_BITS + 3;

    logic signed [DW-1:0] dx_w;
    logic signed [DW-1:0] dy_w;

    always_comb begin
        priority if (i_x0 == i_x1) begin
            o_cur_x  = i_x0;
            o_stop_x = i_x0;
            o_cur_y  = (i_y0 < i_y1) ? i_y0 : i_y1;
            o_stop_y = (i_y0 < i_y1) ? i_y1 : i_y0;
        end else if (i_x0 < i_x1) begin
            o_cur_x  = i_x0;
            o_cur_y  = i_y0;
            o_stop_x = i_x1;
            o_stop_y = i_y1;
        end else begin
            o_cur_x  = i_x1;
            o_cur_y  = i_y1;
            o_stop_x = i_x0;
            o_stop_y = i_y0;
        end
    end

    assign o_delta_x = {1'b0, o_stop_x} - {1'b0, o_cur_x};
    assign o_delta_y = $signed({1'b0, o_stop_y}) - $signed({1'b0, o_cur_y});

    assign dx_w = $signed({2'b00, o_delta_x});
    assign dy_w = {{2{o_delta_y[COORD_BITS]}}, o_delta_y};

    always_comb begin
        o_decision = '0;
        priority if (dx_w == '0) begin
            o_octant = OCT_VERT;
        end else if (dy_w == '0) begin
            o_octant = OCT_HORZ;
        end else if (dy_w == dx_w) begin
            o_octant = OCT_DIAG_UP;
        end else if (dy_w == -dx_w) begin
            o_octant = OCT_DIAG_DN;
        end else if (dy_w > 0 && dy_w < dx_w) begin
            o_octant   = OCT_SHALLOW_UP;
            o_decision = (dy_w <<< 1) - dx_w;
        end else if (dy_w > dx_w) begin
            o_octant   = OCT_STEEP_UP;
            o_decision = dy_w - (dx_w <<< 1);
        end else if (dy_w > -dx_w) begin
            o_octant   = OCT_SHALLOW_DN;
            o_decision = (dy_w <<< 1) + dx_w;
        end else begin
            o_octant   = OCT_STEEP_DN;
            o_decision = dy_w + (dx_w <<< 1);
        end
    end

endmodule

### src/mlr_step.sv
// ----------------------------------------------------------------------------
// mlr_step - one midpoint step
// Moves the current pixel by one and updates the decision term.
// ----------------------------------------------------------------------------
module mlr_step
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]        i_cur_x,
    input  logic [COORD_BITS-1:0]        i_cur_y,
    input  logic [COORD_BITS:0]          i_delta_x,
    input  logic signed [COORD_BITS:0]   i_delta_y,
    input  logic signed [COORD_BITS+2:0] i_decision,
    input  t_octant                      i_octant,
    output logic [COORD_BITS-1:0]        o_cur_x,
    output logic [COORD_BITS-1:0]        o_cur_y,
    output logic signed [COORD_BITS+2:0] o_decision
);

    localparam int DW = COORD_BITS + 3;

    logic signed [DW-1:0]  dx2;
    logic signed [DW-1:0]  dy2;
    logic [COORD_BITS-1:0] x_inc;
    logic [COORD_BITS-1:0] y_inc;
    logic [COORD_BITS-1:0] y_dec;

    assign dx2   = $signed({1'b0, i_delta_x, 1'b0});
    assign dy2   = {i_delta_y[COORD_BITS], i_delta_y, 1'b0};
    assign x_inc = i_cur_x + 1'b1;
    assign y_inc = i_cur_y + 1'b1;
    assign y_dec = i_cur_y - 1'b1;

    always_comb begin
        o_cur_x    = i_cur_x;
        o_cur_y    = i_cur_y;
        o_decision = i_decision;
        unique case (i_octant)
            OCT_HORZ: begin
                o_cur_x = x_inc;
            end
            OCT_DIAG_UP: begin
                o_cur_x = x_inc;
                o_cur_y = y_inc;
            end
            OCT_DIAG_DN: begin
                o_cur_x = x_inc;
                o_cur_y = y_dec;
            end
            OCT_VERT: begin
                o_cur_y = y_inc;
            end
            OCT_SHALLOW_UP: begin
                o_cur_x = x_inc;
                if (i_decision > 0) begin
                    o_cur_y    = y_inc;
                    o_decision = i_decision - dx2 + dy2;
                end else begin
                    o_decision = i_decision + dy2;
                end
            end
            OCT_STEEP_UP: begin
                o_cur_y = y_inc;
                if (i_decision < 0) begin
                    o_cur_x    = x_inc;
                    o_decision = i_decision + dy2 - dx2;
                end else begin
                    o_decision = i_decision - dx2;
                end
            end
            OCT_SHALLOW_DN: begin
                o_cur_x = x_inc;
                if (i_decision < 0) begin
                    o_cur_y    = y_dec;
                    o_decision = i_decision + dx2 + dy2;
                end else begin
                    o_decision = i_decision + dy2;
                end
            end
            OCT_STEEP_DN: begin
                o_cur_y = y_dec;
                if (i_decision > 0) begin
                    o_cur_x    = x_inc;
                    o_decision = i_decision + dy2 + dx2;
                end else begin
                    o_decision = i_decision + dx2;
                end
            end
            default: begin
                o_cur_x = i_cur_x;
            end
        endcase
    end

endmodule

### src/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer - integer midpoint line generator, all octants
// Start items load a line, step items walk it one pixel at a time.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item. The block takes one item
// per clock and gives one result per clock unless i_stall holds the output;
// items pass the input register, then the result register. The line state
// (position, decision term, slope case) is updated in the same cycle as an
// item moves from the input register into the result register, so each
// step is a single add and compare on that state. A start item emits the
// first pixel; each step item emits the next one, with last set on the final
// endpoint. Steps with no line in progress return valid_res = 0 and zero fields.
module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0] i_line_color,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0] o_pixel_color,
    output logic                  o_valid_res,
    output logic                  o_last
);

    localparam int DW = COORD_BITS + 3;

    // input register
    logic                  r_in_valid;
    logic                  r_in_mode;
    logic [COORD_BITS-1:0] r_in_x0, r_in_y0, r_in_x1, r_in_y1;
    logic [COLOR_BITS-1:0] r_in_color;

    // line state
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    logic [COORD_BITS:0]   r_delta_x;
    logic signed [COORD_BITS:0] r_delta_y;
    logic signed [DW-1:0]  r_decision;
    t_octant               r_octant;
    logic                  r_line_active;
    logic [COLOR_BITS-1:0] r_held_color;

    // result register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_valid_res;
    logic                  r_out_last;

    logic move;
    logic fire;

    logic [COORD_BITS-1:0] su_cur_x, su_cur_y, su_stop_x, su_stop_y;
    logic [COORD_BITS:0]   su_delta_x;
    logic signed [COORD_BITS:0] su_delta_y;
    logic signed [DW-1:0]  su_decision;
    t_octant               su_octant;

    logic [COORD_BITS-1:0] st_cur_x, st_cur_y;
    logic signed [DW-1:0]  st_decision;

    logic [COORD_BITS-1:0] n_cur_x, n_cur_y, n_stop_x, n_stop_y;
    logic [COORD_BITS:0]   n_delta_x;
    logic signed [COORD_BITS:0] n_delta_y;
    logic signed [DW-1:0]  n_decision;
    t_octant               n_octant;
    logic [COLOR_BITS-1:0] n_held_color;
    logic                  n_emit;
    logic                  n_last;

    assign move    = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && move;
    assign o_stall = r_in_valid && !move;

    mlr_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .i_x0      (r_in_x0),
        .i_y0      (r_in_y0),
        .i_x1      (r_in_x1),
        .i_y1      (r_in_y1),
        .o_cur_x   (su_cur_x),
        .o_cur_y   (su_cur_y),
        .o_stop_x  (su_stop_x),
        .o_stop_y  (su_stop_y),
        .o_delta_x (su_delta_x),
        .o_delta_y (su_delta_y),
        .o_decision(su_decision),
        .o_octant  (su_octant)
    );

    mlr_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .i_cur_x   (r_cur_x),
        .i_cur_y   (r_cur_y),
        .i_delta_x (r_delta_x),
        .i_delta_y (r_delta_y),
        .i_decision(r_decision),
        .i_octant  (r_octant),
        .o_cur_x   (st_cur_x),
        .o_cur_y   (st_cur_y),
        .o_decision(st_decision)
    );

    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_stop_x     = r_stop_x;
        n_stop_y     = r_stop_y;
        n_delta_x    = r_delta_x;
        n_delta_y    = r_delta_y;
        n_decision   = r_decision;
        n_octant     = r_octant;
        n_held_color = r_held_color;
        n_emit       = 1'b0;
        priority if (r_in_mode == MODE_START) begin
            n_cur_x      = su_cur_x;
            n_cur_y      = su_cur_y;
            n_stop_x     = su_stop_x;
            n_stop_y     = su_stop_y;
            n_delta_x    = su_delta_x;
            n_delta_y    = su_delta_y;
            n_decision   = su_decision;
            n_octant     = su_octant;
            n_held_color = r_in_color;
            n_emit       = 1'b1;
        end else if (r_line_active) begin
            n_cur_x    = st_cur_x;
            n_cur_y    = st_cur_y;
            n_decision = st_decision;
            n_emit     = 1'b1;
        end else begin
            n_emit = 1'b0;
        end
        n_last = (n_cur_x == n_stop_x) && (n_cur_y == n_stop_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_mode  <= i_mode;
            r_in_x0    <= i_start_x;
            r_in_y0    <= i_start_y;
            r_in_x1    <= i_end_x;
            r_in_y1    <= i_end_y;
            r_in_color <= i_line_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_octant      <= OCT_HORZ;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_stop_x      <= '0;
            r_stop_y      <= '0;
            r_delta_x     <= '0;
            r_delta_y     <= '0;
            r_decision    <= '0;
            r_held_color  <= '0;
        end else if (fire && n_emit) begin
            r_line_active <= !n_last;
            r_octant      <= n_octant;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_stop_x      <= n_stop_x;
            r_stop_y      <= n_stop_y;
            r_delta_x     <= n_delta_x;
            r_delta_y     <= n_delta_y;
            r_decision    <= n_decision;
            r_held_color  <= n_held_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_x         <= n_emit ? n_cur_x : '0;
            r_out_y         <= n_emit ? n_cur_y : '0;
            r_out_color     <= n_emit ? n_held_color : '0;
            r_out_valid_res <= n_emit;
            r_out_last      <= n_emit && n_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_valid_res   = r_out_valid_res;
    assign o_last        = r_out_last;

    // a held result always matches the current line state
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_line_active)
        else $error("line still active after last pixel");

    a_mid_keeps_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_valid_res && !r_out_last) |-> r_line_active)
        else $error("line dropped before last pixel");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled with room in result register");

    a_horz_on_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_active && r_octant == OCT_HORZ) |-> (r_cur_y == r_stop_y))
        else $error("horizontal line left its row");

    a_x_not_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_cur_x <= r_stop_x))
        else $error("x walked past the end point");

endmodule

### tb/sv/tb_midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_midpoint_line_rasterizer - self-checking bench for the line rasterizer
// Drives start and step transfers with random gaps and output stalls, traces
// each line with an in-bench midpoint walker, and checks every pixel.
// ----------------------------------------------------------------------------
module tb_midpoint_line_rasterizer;
    import mlr_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;
    localparam int RANDOM_ITEMS = 1600;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COLOR_BITS-1:0] t_color;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_color color;
        logic   valid_res;
        logic   last;
    } t_pixel;

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_valid      = 1'b0;
    logic   i_mode       = MODE_START;
    t_coord i_start_x    = '0;
    t_coord i_start_y    = '0;
    t_coord i_end_x      = '0;
    t_coord i_end_y      = '0;
    t_color i_line_color = '0;
    logic   i_stall      = 1'b0;
    logic   o_stall;
    logic   o_valid;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    t_color o_pixel_color;
    logic   o_valid_res;
    logic   o_last;

    midpoint_line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_color(o_pixel_color),
        .o_valid_res  (o_valid_res),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Line walker state, a private copy of the block's line registers
    t_coord   walk_x, walk_y, goal_x, goal_y;
    int       run_dx, run_dy, err_term;
    t_octant  slope;
    logic     line_on  = 1'b0;
    t_color   line_rgb;

    t_pixel   pending_pixels[$];
    int       mismatch_count = 0;
    int       items_sent     = 0;
    int       cycle_count    = 0;
    logic     feed_gaps      = 1'b0;
    logic     drain_gaps     = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= drain_gaps && ($urandom_range(99) < 8);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Next pixel of the line being walked; err_term follows the midpoint rule
    function automatic t_pixel trace_pixel(input logic mode, input t_coord sx, input t_coord sy,
                                           input t_coord ex, input t_coord ey,
                                           input t_color rgb);
        t_pixel px;
        logic   fin;
        if (mode == MODE_START) begin
            line_rgb = rgb;
            if (sx == ex) begin
                walk_x = sx;
                goal_x = sx;
                walk_y = (sy < ey) ? sy : ey;
                goal_y = (sy < ey) ? ey : sy;
            end else if (sx < ex) begin
                walk_x = sx; walk_y = sy; goal_x = ex; goal_y = ey;
            end else begin
                walk_x = ex; walk_y = ey; goal_x = sx; goal_y = sy;
            end
            run_dx   = int'(goal_x) - int'(walk_x);
            run_dy   = int'(goal_y) - int'(walk_y);
            err_term = 0;
            if (run_dx == 0)
                slope = OCT_VERT;
            else if (run_dy == 0)
                slope = OCT_HORZ;
            else if (run_dy == run_dx)
                slope = OCT_DIAG_UP;
            else if (run_dy == -run_dx)
                slope = OCT_DIAG_DN;
            else if (run_dy > 0 && run_dy < run_dx) begin
                slope = OCT_SHALLOW_UP;
                err_term = 2 * run_dy - run_dx;
            end else if (run_dy > run_dx) begin
                slope = OCT_STEEP_UP;
                err_term = run_dy - 2 * run_dx;
            end else if (run_dy > -run_dx) begin
                slope = OCT_SHALLOW_DN;
                err_term = 2 * run_dy + run_dx;
            end else begin
                slope = OCT_STEEP_DN;
                err_term = run_dy + 2 * run_dx;
            end
        end else if (!line_on) begin
            return '0;
        end else begin
            case (slope)
                OCT_HORZ:    walk_x++;
                OCT_DIAG_UP: begin walk_x++; walk_y++; end
                OCT_DIAG_DN: begin walk_x++; walk_y--; end
                OCT_VERT:    walk_y++;
                OCT_SHALLOW_UP: begin
                    if (err_term > 0) begin
                        err_term -= 2 * run_dx;
                        walk_y++;
                    end
                    err_term += 2 * run_dy;
                    walk_x++;
                end
                OCT_STEEP_UP: begin
                    if (err_term < 0) begin
                        err_term += 2 * run_dy;
                        walk_x++;
                    end
                    err_term -= 2 * run_dx;
                    walk_y++;
                end
                OCT_SHALLOW_DN: begin
                    if (err_term < 0) begin
                        err_term += 2 * run_dx;
                        walk_y--;
                    end
                    err_term += 2 * run_dy;
                    walk_x++;
                end
                default: begin
                    if (err_term > 0) begin
                        err_term += 2 * run_dy;
                        walk_x++;
                    end
                    err_term += 2 * run_dx;
                    walk_y--;
                end
            endcase
        end
        fin          = (walk_x == goal_x) && (walk_y == goal_y);
        line_on      = !fin;
        px.x         = walk_x;
        px.y         = walk_y;
        px.color     = line_rgb;
        px.valid_res = 1'b1;
        px.last      = fin;
        return px;
    endfunction

    // Ends at the falling edge after the transfer; valid stays high for the next item
    task automatic send_item(input logic mode, input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey, input t_color rgb);
        while (feed_gaps && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_start_x    <= sx;
        i_start_y    <= sy;
        i_end_x      <= ex;
        i_end_y      <= ey;
        i_line_color <= rgb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_pixels.push_back(trace_pixel(mode, sx, sy, ex, ey, rgb));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Step with junk in the unused fields
    task automatic send_step();
        send_item(MODE_STEP, t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), t_color'($urandom));
    endtask

    // Start a line, walk it (or stop after cut_after steps), then overrun
    task automatic run_line(input t_coord x0, input t_coord y0, input t_coord x1,
                            input t_coord y1, input t_color rgb, input int cut_after,
                            input int extra_steps);
        int n;
        n = 0;
        send_item(MODE_START, x0, y0, x1, y1, rgb);
        while (line_on && n != cut_after) begin
            send_step();
            n++;
        end
        repeat (extra_steps) send_step();
    endtask

    function automatic t_coord clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return t_coord'(COORD_MAX);
        return t_coord'(v);
    endfunction

    function automatic t_coord edge_or_random();
        case ($urandom_range(9))
            0:       return '0;
            1:       return t_coord'(COORD_MAX);
            default: return t_coord'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with none expected, x", o_pixel_x, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_x !== want.x)
                    report_mismatch("pixel_x", o_pixel_x, want.x);
                if (o_pixel_y !== want.y)
                    report_mismatch("pixel_y", o_pixel_y, want.y);
                if (o_pixel_color !== want.color)
                    report_mismatch("pixel_color", o_pixel_color, want.color);
                if (o_valid_res !== want.valid_res)
                    report_mismatch("valid_res", o_valid_res, want.valid_res);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    task automatic test_step_without_line();
        send_step();
    endtask

    task automatic test_single_point();
        run_line(12'd4095, 12'd0, 12'd4095, 12'd0, 24'hFFFFFF, -1, 1);
    endtask

    task automatic test_exact_cases();
        run_line(12'd4095, 12'd7, 12'd4093, 12'd7, 24'h00FF00, -1, 0);
        run_line(12'd0, 12'd0, 12'd1, 12'd1, 24'h000001, -1, 0);
        run_line(12'd1, 12'd4094, 12'd0, 12'd4095, 24'h800000, -1, 0);
        run_line(12'd5, 12'd4095, 12'd5, 12'd4093, 24'h0000FF, -1, 0);
    endtask

    task automatic test_abandoned_line();
        run_line(12'd0, 12'd0, 12'd4095, 12'd4095, 24'h000000, 1, 0);
    endtask

    task automatic test_slope_octants();
        run_line(12'd10, 12'd10, 12'd12, 12'd11, 24'h123456, -1, 0);
        run_line(12'd10, 12'd10, 12'd11, 12'd12, 24'h654321, -1, 0);
        run_line(12'd10, 12'd11, 12'd12, 12'd10, 24'hA5A5A5, -1, 0);
        run_line(12'd10, 12'd12, 12'd11, 12'd10, 24'h5A5A5A, -1, 0);
    endtask

    task automatic test_random_lines(input int count);
        int     stop_at, quiet_until, span, ddx, ddy, pick;
        t_coord x0, y0;
        stop_at     = items_sent + count;
        quiet_until = items_sent + 300;
        while (items_sent < stop_at) begin
            if (items_sent >= quiet_until && $urandom_range(19) == 0) begin
                feed_gaps  = ($urandom_range(3) != 0);
                drain_gaps = ($urandom_range(3) != 0);
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                // broken sequence: random endpoints, at most three steps, then dropped
                run_line(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                         t_coord'($urandom), t_color'($urandom), $urandom_range(3), 0);
            end else if (pick < 8) begin
                send_step();
            end else begin
                x0   = edge_or_random();
                y0   = edge_or_random();
                span = ($urandom_range(99) < 5) ? 200 : 12;
                ddx  = int'($urandom_range(2 * span)) - span;
                ddy  = int'($urandom_range(2 * span)) - span;
                case ($urandom_range(7))
                    0: ddx = 0;
                    1: ddy = 0;
                    2: ddy = ddx;
                    3: ddy = -ddx;
                    default: ;
                endcase
                run_line(x0, y0, clamp_coord(int'(x0) + ddx), clamp_coord(int'(y0) + ddy),
                         t_color'($urandom), (pick < 18) ? int'($urandom_range(4)) : -1,
                         ($urandom_range(3) == 0) ? int'($urandom_range(2)) : 0);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_step_without_line();
        test_single_point();
        test_exact_cases();
        test_abandoned_line();
        test_slope_octants();
        test_random_lines(RANDOM_ITEMS);

        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
